### hw/rtl/pgmc_pkg.sv
// ----------------------------------------------------------------------------
// pgmc_pkg
// Shared types, widths and constants of the polar goal motion controller.
// ----------------------------------------------------------------------------
package pgmc_pkg;

  localparam int FracBits  = 12;
  localparam int AngFrac   = 16;
  localparam int AngShift  = AngFrac - FracBits;

  localparam int InW       = 16;
  localparam int HdW       = 15;
  localparam int DW        = InW + 1;
  localparam int AngW      = 20;
  localparam int AngQW     = 19;
  localparam int WrapW     = 22;

  localparam int CfgW      = 15;
  localparam int GainW     = 16;
  localparam int CfgDataW  = 16;
  localparam int RegIdxW   = 3;

  localparam int OutW      = 20;
  localparam int NumW      = 41;
  localparam int DivShift  = 8;

  localparam int Steps     = 17;
  localparam int CW        = 34;
  localparam int ZW        = 20;
  localparam int RhoW      = Steps;
  localparam int NW        = 2 * Steps;
  localparam int CordicPre = 14;

  localparam int QDepth    = 4;

  localparam logic signed [ZW-1:0]    PiZ     = 20'sd205887;
  localparam logic signed [AngQW-1:0] TurnLim = 19'sd58983;

  localparam logic signed [WrapW-1:0] Pi1 = 22'sd205887;
  localparam logic signed [WrapW-1:0] Pi2 = 22'sd411774;
  localparam logic signed [WrapW-1:0] Pi3 = 22'sd617661;
  localparam logic signed [WrapW-1:0] Pi4 = 22'sd823548;

  localparam logic signed [ZW-1:0] AtanTab [Steps] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024, 20'sd512, 20'sd256, 20'sd128, 20'sd64, 20'sd32, 20'sd16,
    20'sd8, 20'sd4, 20'sd2, 20'sd1
  };

  localparam logic [CfgW-1:0]         RstGainDistance  = 15'd287;
  localparam logic signed [GainW-1:0] RstGainBearing   = 16'sd8192;
  localparam logic signed [GainW-1:0] RstGainFinalHead = -16'sd1024;
  localparam logic [CfgW-1:0]         RstWheelRadius   = 15'd133;
  localparam logic [CfgW-1:0]         RstAxleHalf      = 15'd307;
  localparam logic [CfgW-1:0]         RstMinSpeed      = 15'd819;
  localparam logic [CfgW-1:0]         RstArriveRadius  = 15'd205;

  typedef enum logic [RegIdxW-1:0] {
    RegGainDistance  = 3'd0,
    RegGainBearing   = 3'd1,
    RegGainFinalHead = 3'd2,
    RegLeftRadius    = 3'd3,
    RegRightRadius   = 3'd4,
    RegAxleHalf      = 3'd5,
    RegMinSpeed      = 3'd6,
    RegArriveRadius  = 3'd7
  } pgmc_reg_e;

  typedef struct packed {
    logic [CfgW-1:0]         gain_distance;
    logic signed [GainW-1:0] gain_bearing;
    logic signed [GainW-1:0] gain_final_heading;
    logic [CfgW-1:0]         left_wheel_radius;
    logic [CfgW-1:0]         right_wheel_radius;
    logic [CfgW-1:0]         axle_half_length;
    logic [CfgW-1:0]         min_speed;
    logic [CfgW-1:0]         arrive_radius;
  } pgmc_cfg_t;

  typedef struct packed {
    logic signed [DW-1:0]    dx;
    logic signed [DW-1:0]    dy;
    logic                    left;
    logic                    zero;
    logic signed [AngW-1:0]  ph;
    logic signed [AngW-1:0]  gh;
    logic signed [AngQW-1:0] dtheta;
  } pgmc_item_t;

  function automatic logic signed [AngQW-1:0] wrap_ang(input logic signed [WrapW-1:0] a);
    logic signed [WrapW-1:0] r;
    priority if (a > Pi3) r = a - Pi4;
    else if (a > Pi1)     r = a - Pi2;
    else if (a < -Pi3)    r = a + Pi4;
    else if (a < -Pi1)    r = a + Pi2;
    else                  r = a;
    return r[AngQW-1:0];
  endfunction

endpackage

### hw/rtl/polar_goal_motion_controller_unit.sv
// ----------------------------------------------------------------------------
// polar_goal_motion_controller_unit
// Differential drive polar pose controller: pose and goal in, wheel speed
// commands, goal-reached and saturation flags out.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle while the queue is not
// full, and each gives one result after the input register, 4-entry queue, 18
// stages of CORDIC and square root, 7 control-law stages, 21 divider stages and
// the output register. The pipeline advances whenever the output register is
// empty or being taken; the queue absorbs the input register while it holds.
// Configuration writes are accepted every cycle and take effect at once on
// every stage, so write them only while no transaction is in flight.
// ----------------------------------------------------------------------------
module polar_goal_motion_controller_unit import pgmc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [RegIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [InW-1:0]   pose_x_i,
  input  logic signed [InW-1:0]   pose_y_i,
  input  logic signed [HdW-1:0]   pose_heading_i,
  input  logic signed [InW-1:0]   goal_x_i,
  input  logic signed [InW-1:0]   goal_y_i,
  input  logic signed [HdW-1:0]   goal_heading_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OutW-1:0]  left_speed_o,
  output logic signed [OutW-1:0]  right_speed_o,
  output logic                    reached_o,
  output logic                    saturated_o
);

  pgmc_cfg_t  cfg_q;
  pgmc_item_t front_item, queue_item;
  logic       push, full, pop, empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_distance      <= RstGainDistance;
      cfg_q.gain_bearing       <= RstGainBearing;
      cfg_q.gain_final_heading <= RstGainFinalHead;
      cfg_q.left_wheel_radius  <= RstWheelRadius;
      cfg_q.right_wheel_radius <= RstWheelRadius;
      cfg_q.axle_half_length   <= RstAxleHalf;
      cfg_q.min_speed          <= RstMinSpeed;
      cfg_q.arrive_radius      <= RstArriveRadius;
    end else if (cfg_valid_i) begin
      unique case (pgmc_reg_e'(cfg_index_i))
        RegGainDistance:  cfg_q.gain_distance      <= cfg_data_i[CfgW-1:0];
        RegGainBearing:   cfg_q.gain_bearing       <= $signed(cfg_data_i);
        RegGainFinalHead: cfg_q.gain_final_heading <= $signed(cfg_data_i);
        RegLeftRadius:    cfg_q.left_wheel_radius  <= cfg_data_i[CfgW-1:0];
        RegRightRadius:   cfg_q.right_wheel_radius <= cfg_data_i[CfgW-1:0];
        RegAxleHalf:      cfg_q.axle_half_length   <= cfg_data_i[CfgW-1:0];
        RegMinSpeed:      cfg_q.min_speed          <= cfg_data_i[CfgW-1:0];
        RegArriveRadius:  cfg_q.arrive_radius      <= cfg_data_i[CfgW-1:0];
        default: ;
      endcase
    end
  end

  pgmc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pose_x_i       (pose_x_i),
    .pose_y_i       (pose_y_i),
    .pose_heading_i (pose_heading_i),
    .goal_x_i       (goal_x_i),
    .goal_y_i       (goal_y_i),
    .goal_heading_i (goal_heading_i),
    .full_i         (full),
    .push_o         (push),
    .item_o         (front_item)
  );

  pgmc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (queue_item),
    .empty_o (empty)
  );

  pgmc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_i        (queue_item),
    .item_valid_i  (!empty),
    .item_pop_o    (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .left_speed_o  (left_speed_o),
    .right_speed_o (right_speed_o),
    .reached_o     (reached_o),
    .saturated_o   (saturated_o)
  );

endmodule

### hw/rtl/pgmc_front.sv
// ----------------------------------------------------------------------------
// pgmc_front
// Input stage: registers a pose/goal transaction and classifies it into
// offsets, scaled headings, wrapped heading error and left/zero flags.
// ----------------------------------------------------------------------------
module pgmc_front import pgmc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [InW-1:0]  pose_x_i,
  input  logic signed [InW-1:0]  pose_y_i,
  input  logic signed [HdW-1:0]  pose_heading_i,
  input  logic signed [InW-1:0]  goal_x_i,
  input  logic signed [InW-1:0]  goal_y_i,
  input  logic signed [HdW-1:0]  goal_heading_i,
  input  logic                   full_i,
  output logic                   push_o,
  output pgmc_item_t             item_o
);

  logic                  vld_q;
  logic signed [InW-1:0] px_q, py_q, gx_q, gy_q;
  logic signed [HdW-1:0] ph_q, gh_q;
  logic                  accept;

  assign push_o     = vld_q && !full_i;
  assign in_ready_o = !vld_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (accept) begin
      vld_q <= 1'b1;
    end else if (push_o) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pose_x_i;
      py_q <= pose_y_i;
      ph_q <= pose_heading_i;
      gx_q <= goal_x_i;
      gy_q <= goal_y_i;
      gh_q <= goal_heading_i;
    end
  end

  always_comb begin
    item_o.dx     = DW'(gx_q) - DW'(px_q);
    item_o.dy     = DW'(gy_q) - DW'(py_q);
    item_o.left   = item_o.dx[DW-1];
    item_o.zero   = (item_o.dx == '0) && (item_o.dy == '0);
    item_o.ph     = AngW'(ph_q) <<< AngShift;
    item_o.gh     = AngW'(gh_q) <<< AngShift;
    item_o.dtheta = wrap_ang(WrapW'(item_o.gh) - WrapW'(item_o.ph));
  end

endmodule

### hw/rtl/pgmc_fifo.sv
// ----------------------------------------------------------------------------
// pgmc_fifo
// Short queue between the classifying front and the execution pipeline.
// ----------------------------------------------------------------------------
module pgmc_fifo import pgmc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pgmc_item_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output pgmc_item_t data_o,
  output logic       empty_o
);

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  pgmc_item_t      mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = cnt_q == CntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

### hw/rtl/pgmc_polar.sv
// ----------------------------------------------------------------------------
// pgmc_polar
// Pipelined vectoring CORDIC for the goal bearing and digit-by-digit square
// root for the goal distance, one step per stage.
// ----------------------------------------------------------------------------
module pgmc_polar import pgmc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  adv_i,
  input  logic signed [DW-1:0]  dx_i,
  input  logic signed [DW-1:0]  dy_i,
  input  logic                  left_i,
  input  logic                  zero_i,
  output logic signed [ZW-1:0]  z_o,
  output logic [RhoW-1:0]       rho_o
);

  localparam int SqW = RhoW + 3;

  logic signed [CW-1:0] x_q [Steps];
  logic signed [CW-1:0] y_q [Steps];
  logic signed [ZW-1:0] z_q [Steps+1];
  logic                 zero_q [Steps+1];
  logic [NW-1:0]        n_q [Steps];
  logic [SqW-1:0]       rem_q [Steps];
  logic [RhoW-1:0]      root_q [Steps+1];

  logic signed [CW-1:0] xe, ye, sqx, sqy;

  assign xe  = CW'(dx_i) <<< CordicPre;
  assign ye  = CW'(dy_i) <<< CordicPre;
  assign sqx = dx_i * dx_i;
  assign sqy = dy_i * dy_i;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (left_i) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= dy_i[DW-1] ? -PiZ : PiZ;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
      zero_q[0] <= zero_i;
      n_q[0]    <= $unsigned(sqx) + $unsigned(sqy);
      rem_q[0]  <= '0;
      root_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic signed [CW-1:0] xs, ys;
    logic [SqW-1:0]       remn, trial;
    logic                 ge;

    assign xs    = x_q[k] >>> k;
    assign ys    = y_q[k] >>> k;
    assign remn  = {rem_q[k][SqW-3:0], n_q[k][2*(Steps-1-k)+1 -: 2]};
    assign trial = {1'b0, root_q[k], 2'b01};
    assign ge    = remn >= trial;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        z_q[k+1]    <= (y_q[k] > 0) ? z_q[k] + AtanTab[k] : z_q[k] - AtanTab[k];
        zero_q[k+1] <= zero_q[k];
        root_q[k+1] <= {root_q[k][RhoW-2:0], ge};
      end
    end

    if (k < Steps - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          if (y_q[k] > 0) begin
            x_q[k+1] <= x_q[k] + ys;
            y_q[k+1] <= y_q[k] - xs;
          end else begin
            x_q[k+1] <= x_q[k] - ys;
            y_q[k+1] <= y_q[k] + xs;
          end
          n_q[k+1]   <= n_q[k];
          rem_q[k+1] <= ge ? remn - trial : remn;
        end
      end
    end
  end

  assign z_o   = zero_q[Steps] ? '0 : z_q[Steps];
  assign rho_o = root_q[Steps];

endmodule

### hw/rtl/pgmc_wheel_div.sv
// ----------------------------------------------------------------------------
// pgmc_wheel_div
// Pipelined restoring divider: wheel term over radius times 256, truncated
// toward zero, with overflow detect for results beyond the output range.
// ----------------------------------------------------------------------------
module pgmc_wheel_div import pgmc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   adv_i,
  input  logic signed [NumW-1:0] num_i,
  input  logic [CfgW-1:0]        rad_i,
  output logic [OutW-1:0]        quo_o,
  output logic                   ovf_o,
  output logic                   neg_o
);

  localparam int HiW = NumW - OutW - DivShift;

  logic [CfgW-1:0] rem_q  [OutW];
  logic [OutW-1:0] bits_q [OutW];
  logic [OutW-1:0] quo_q  [OutW+1];
  logic            ovf_q  [OutW+1];
  logic            neg_q  [OutW+1];
  logic            nz_q   [OutW+1];

  logic [NumW-1:0] mag;
  logic [HiW-1:0]  hi;

  assign mag = num_i[NumW-1] ? $unsigned(-num_i) : $unsigned(num_i);
  assign hi  = mag[NumW-1 -: HiW];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q[0]  <= CfgW'(hi);
      bits_q[0] <= mag[OutW+DivShift-1:DivShift];
      quo_q[0]  <= '0;
      neg_q[0]  <= num_i[NumW-1];
      nz_q[0]   <= num_i != '0;
      ovf_q[0]  <= (rad_i == '0) ? (num_i != '0) : (CfgW'(hi) >= rad_i);
    end
  end

  for (genvar k = 0; k < OutW; k++) begin : g_step
    logic [CfgW:0] remn;
    logic          ge;

    assign remn = {rem_q[k], bits_q[k][OutW-1]};
    assign ge   = remn >= {1'b0, rad_i};

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        quo_q[k+1] <= {quo_q[k][OutW-2:0], ge};
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
        nz_q[k+1]  <= nz_q[k];
      end
    end

    if (k < OutW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          rem_q[k+1]  <= ge ? CfgW'(remn - {1'b0, rad_i}) : remn[CfgW-1:0];
          bits_q[k+1] <= {bits_q[k][OutW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = nz_q[OutW] ? quo_q[OutW] : '0;
  assign ovf_o = ovf_q[OutW];
  assign neg_o = neg_q[OutW];

endmodule

### hw/rtl/pgmc_back.sv
// ----------------------------------------------------------------------------
// pgmc_back
// Execution pipeline: polar conversion, control law, wheel division,
// clipping, arrival override and the output register.
// ----------------------------------------------------------------------------
module pgmc_back import pgmc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pgmc_cfg_t              cfg_i,
  input  pgmc_item_t             item_i,
  input  logic                   item_valid_i,
  output logic                   item_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] left_speed_o,
  output logic signed [OutW-1:0] right_speed_o,
  output logic                   reached_o,
  output logic                   saturated_o
);

  localparam int PolarLat = Steps + 1;
  localparam int CtlLat   = 7;
  localparam int DivLat   = OutW + 1;
  localparam int TotLat   = PolarLat + CtlLat + DivLat;
  localparam int SpinW    = AngQW - 7;
  localparam int VProdW   = CfgW + RhoW;
  localparam int VW       = VProdW - FracBits;
  localparam int PW       = GainW + AngQW;
  localparam int SumW     = PW + 1;
  localparam int WW       = SumW - FracBits;
  localparam int LW       = CfgW + 1 + WW;
  localparam int VShift   = AngFrac + 1;

  localparam logic signed [OutW-1:0] OutMax    = 20'sh7FFFF;
  localparam logic signed [OutW-1:0] OutMin    = 20'sh80000;
  localparam logic [OutW-1:0]        OutMinMag = 20'h80000;

  typedef struct packed {
    logic signed [AngW-1:0]  ph;
    logic signed [AngW-1:0]  gh;
    logic signed [AngQW-1:0] dtheta;
  } side_t;

  typedef struct packed {
    logic                    near;
    logic                    turn;
    logic signed [SpinW-1:0] spin;
  } arr_t;

  typedef struct packed {
    logic signed [OutW-1:0] val;
    logic                   sat;
  } whl_t;

  function automatic whl_t clip_whl(input logic neg, input logic ovf,
                                    input logic [OutW-1:0] q);
    whl_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (ovf || q[OutW-1]) begin
        r.val = OutMax;
        r.sat = 1'b1;
      end else begin
        r.val = $signed(q);
      end
    end else if (ovf || q > OutMinMag) begin
      r.val = OutMin;
      r.sat = 1'b1;
    end else begin
      r.val = $signed(~q + OutW'(1));
    end
    return r;
  endfunction

  logic              adv;
  logic [TotLat-1:0] vld_q;
  logic              out_vld_q;
  side_t             sb_q [PolarLat];
  arr_t              arr_dl_q [DivLat];

  logic signed [ZW-1:0]   z;
  logic [RhoW-1:0]        rho;

  logic signed [AngQW-1:0] atg1_q, alpha2_q, alpha3_q, beta3_q;
  logic [VProdW-1:0]       vprod1_q;
  logic signed [AngW-1:0]  ph1_q, gh1_q, ph2_q, gh2_q;
  logic [VW-1:0]           v2_q, v3_q, v4_q, v5_q, v6_q;
  logic signed [PW-1:0]    pa4_q, pb4_q;
  logic signed [WW-1:0]    w5_q;
  logic signed [LW-1:0]    lw6_q;
  logic signed [NumW-1:0]  wr7_q, wl7_q;
  arr_t                    arr1_q, arr2_q, arr3_q, arr4_q, arr5_q, arr6_q, arr7_q;

  logic [VW-1:0]          vsh;
  logic signed [SumW-1:0] wsum, wsh;
  logic signed [NumW-1:0] vs;
  side_t                  sb_end;

  logic [OutW-1:0] quo_l, quo_r;
  logic            ovf_l, ovf_r, neg_l, neg_r;
  whl_t            whl_l, whl_r;
  arr_t            arr_end;
  logic signed [OutW-1:0] left_d, right_d;
  logic            reached_d, sat_d;

  assign adv        = !out_vld_q || out_ready_i;
  assign item_pop_o = adv && item_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[TotLat-2:0], item_valid_i};
      out_vld_q <= vld_q[TotLat-1];
    end
  end

  pgmc_polar u_polar (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .dx_i   (item_i.dx),
    .dy_i   (item_i.dy),
    .left_i (item_i.left),
    .zero_i (item_i.zero),
    .z_o    (z),
    .rho_o  (rho)
  );

  assign sb_end = sb_q[PolarLat-1];
  assign vsh    = vprod1_q[VProdW-1:FracBits];
  assign wsum   = SumW'(pa4_q) + SumW'(pb4_q);
  assign wsh    = wsum >>> FracBits;
  assign vs     = $signed(NumW'(v6_q)) <<< VShift;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb_q[0] <= '{ph: item_i.ph, gh: item_i.gh, dtheta: item_i.dtheta};
      for (int i = 1; i < PolarLat; i++) sb_q[i] <= sb_q[i-1];

      atg1_q      <= wrap_ang(WrapW'(z));
      vprod1_q    <= VProdW'(cfg_i.gain_distance) * VProdW'(rho);
      ph1_q       <= sb_end.ph;
      gh1_q       <= sb_end.gh;
      arr1_q.near <= rho < RhoW'(cfg_i.arrive_radius);
      arr1_q.turn <= (sb_end.dtheta >= TurnLim) || (sb_end.dtheta <= -TurnLim);
      arr1_q.spin <= sb_end.dtheta[AngQW-1:7];

      alpha2_q <= wrap_ang(WrapW'(atg1_q) - WrapW'(ph1_q));
      v2_q     <= (vsh < VW'(cfg_i.min_speed)) ? VW'(cfg_i.min_speed) : vsh;
      ph2_q    <= ph1_q;
      gh2_q    <= gh1_q;
      arr2_q   <= arr1_q;

      beta3_q  <= wrap_ang(WrapW'(gh2_q) - WrapW'(ph2_q) - WrapW'(alpha2_q));
      alpha3_q <= alpha2_q;
      v3_q     <= v2_q;
      arr3_q   <= arr2_q;

      pa4_q  <= PW'(cfg_i.gain_bearing) * PW'(alpha3_q);
      pb4_q  <= PW'(cfg_i.gain_final_heading) * PW'(beta3_q);
      v4_q   <= v3_q;
      arr4_q <= arr3_q;

      w5_q   <= wsh[WW-1:0];
      v5_q   <= v4_q;
      arr5_q <= arr4_q;

      lw6_q  <= LW'($signed({1'b0, cfg_i.axle_half_length})) * LW'(w5_q);
      v6_q   <= v5_q;
      arr6_q <= arr5_q;

      wr7_q  <= vs + NumW'(lw6_q);
      wl7_q  <= vs - NumW'(lw6_q);
      arr7_q <= arr6_q;

      arr_dl_q[0] <= arr7_q;
      for (int i = 1; i < DivLat; i++) arr_dl_q[i] <= arr_dl_q[i-1];
    end
  end

  pgmc_wheel_div u_div_left (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (wl7_q),
    .rad_i (cfg_i.left_wheel_radius),
    .quo_o (quo_l),
    .ovf_o (ovf_l),
    .neg_o (neg_l)
  );

  pgmc_wheel_div u_div_right (
    .clk_i (clk_i),
    .adv_i (adv),
    .num_i (wr7_q),
    .rad_i (cfg_i.right_wheel_radius),
    .quo_o (quo_r),
    .ovf_o (ovf_r),
    .neg_o (neg_r)
  );

  assign arr_end = arr_dl_q[DivLat-1];

  always_comb begin
    whl_l     = clip_whl(neg_l, ovf_l, quo_l);
    whl_r     = clip_whl(neg_r, ovf_r, quo_r);
    left_d    = whl_l.val;
    right_d   = whl_r.val;
    sat_d     = whl_l.sat || whl_r.sat;
    reached_d = 1'b0;
    if (arr_end.near) begin
      sat_d = 1'b0;
      if (arr_end.turn) begin
        right_d = OutW'(arr_end.spin);
        left_d  = -OutW'(arr_end.spin);
      end else begin
        right_d   = '0;
        left_d    = '0;
        reached_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      left_speed_o  <= left_d;
      right_speed_o <= right_d;
      reached_o     <= reached_d;
      saturated_o   <= sat_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polar goal motion controller: random and corner
// pose/goal pairs under several register settings, wheel speeds and flags
// predicted per transaction and compared in order against the block output.
// ----------------------------------------------------------------------------
module tb_top;
  import pgmc_pkg::*;

  localparam int  CycleLimit = 300000;
  localparam int  DrainWait  = 64;
  localparam longint PiQ     = 205887;
  localparam longint TurnQ   = 58983;
  localparam longint SpdMax  = 524287;
  localparam longint SpdMin  = -524288;

  typedef struct {
    logic signed [InW-1:0] px, py, gx, gy;
    logic signed [HdW-1:0] ph, gh;
  } pose_pair_t;

  typedef struct {
    logic signed [OutW-1:0] left, right;
    logic                   reached, sat;
  } wheel_cmd_t;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [RegIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [InW-1:0] pose_x, pose_y, goal_x, goal_y;
  logic signed [HdW-1:0] pose_hd, goal_hd;
  logic signed [OutW-1:0] left_spd, right_spd;
  logic reached, saturated;

  pose_pair_t pending_pairs[$];
  wheel_cmd_t expected_cmds[$];
  logic [CfgDataW-1:0] reg_shadow [8];
  int  errors, cycles, pushed_cnt, accepted_cnt;
  logic in_taken, cfg_taken;
  logic hold_req, hold_done;
  int  hold_cnt, burst_left, gap_left, rcv_mode, rcv_cnt;

  polar_goal_motion_controller_unit uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .pose_x_i(pose_x), .pose_y_i(pose_y), .pose_heading_i(pose_hd),
    .goal_x_i(goal_x), .goal_y_i(goal_y), .goal_heading_i(goal_hd),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .left_speed_o(left_spd), .right_speed_o(right_spd),
    .reached_o(reached), .saturated_o(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint wrap_pi(longint a);
    while (a > PiQ) a -= 2 * PiQ;
    while (a < -PiQ) a += 2 * PiQ;
    return a;
  endfunction

  function automatic longint floor_sqrt(longint n);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint bearing_of(longint dy, longint dx);
    longint x, y, z, t;
    if (dx == 0 && dy == 0) return 0;
    x = dx * 16384;
    y = dy * 16384;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PiQ : -PiQ;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Steps; i++) begin
      if (y > 0) begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(AtanTab[i]);
      end else begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(AtanTab[i]);
      end
      x = t;
    end
    return z;
  endfunction

  function automatic longint wheel_rate(longint num, longint radius, ref logic sat);
    longint q;
    if (radius == 0) q = (num > 0) ? (longint'(1) << 40) : (num < 0) ? -(longint'(1) << 40) : 0;
    else q = num / (radius * 256);
    if (q > SpdMax) begin
      sat = 1'b1;
      q = SpdMax;
    end else if (q < SpdMin) begin
      sat = 1'b1;
      q = SpdMin;
    end
    return q;
  endfunction

  function automatic wheel_cmd_t predict_wheels(pose_pair_t p);
    wheel_cmd_t c;
    longint ph, gh, dx, dy, dth, rho, alpha, beta, ka, kb, v, w, lw, wr, wl, lft, rgt;
    logic sat;
    ph    = longint'(p.ph) * (1 << AngShift);
    gh    = longint'(p.gh) * (1 << AngShift);
    dx    = longint'(p.gx) - longint'(p.px);
    dy    = longint'(p.gy) - longint'(p.py);
    dth   = wrap_pi(gh - ph);
    rho   = floor_sqrt(dx * dx + dy * dy);
    alpha = wrap_pi(wrap_pi(bearing_of(dy, dx)) - ph);
    beta  = wrap_pi(gh - ph - alpha);
    ka    = longint'($signed(reg_shadow[RegGainBearing]));
    kb    = longint'($signed(reg_shadow[RegGainFinalHead]));
    sat   = 1'b0;
    v = (longint'(reg_shadow[RegGainDistance]) * rho) >>> FracBits;
    if (v < longint'(reg_shadow[RegMinSpeed])) v = longint'(reg_shadow[RegMinSpeed]);
    w   = (ka * alpha + kb * beta) >>> FracBits;
    lw  = longint'(reg_shadow[RegAxleHalf]) * w;
    wr  = v * 131072 + lw;
    wl  = wr - 2 * lw;
    lft = wheel_rate(wl, longint'(reg_shadow[RegLeftRadius]), sat);
    rgt = wheel_rate(wr, longint'(reg_shadow[RegRightRadius]), sat);
    c.reached = 1'b0;
    if (rho < longint'(reg_shadow[RegArriveRadius])) begin
      sat = 1'b0;
      if (dth >= TurnQ || dth <= -TurnQ) begin
        rgt = dth >>> 7;
        lft = -rgt;
      end else begin
        rgt = 0;
        lft = 0;
        c.reached = 1'b1;
      end
    end
    c.left  = lft[OutW-1:0];
    c.right = rgt[OutW-1:0];
    c.sat   = sat;
    return c;
  endfunction

  task automatic report(string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // hold the item until the handshake, otherwise advance through bursts and gaps
  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() > 0) begin
        pose_pair_t p;
        p = pending_pairs.pop_front();
        pose_x <= p.px;
        pose_y <= p.py;
        pose_hd <= p.ph;
        goal_x <= p.gx;
        goal_y <= p.gy;
        goal_hd <= p.gh;
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      if (rcv_cnt == 0) begin
        rcv_mode <= $urandom_range(0, 2);
        rcv_cnt <= $urandom_range(10, 80);
      end else begin
        rcv_cnt <= rcv_cnt - 1;
      end
      case (rcv_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    wheel_cmd_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("polar_goal_motion_controller_unit test failed");
      $finish;
    end
    in_taken  <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == RegGainBearing || cfg_index == RegGainFinalHead)
        reg_shadow[cfg_index] = cfg_data;
      else
        reg_shadow[cfg_index] = {1'b0, cfg_data[CfgW-1:0]};
    end
    if (rst_n && in_valid && in_ready) begin
      pose_pair_t p;
      p.px = pose_x; p.py = pose_y; p.ph = pose_hd;
      p.gx = goal_x; p.gy = goal_y; p.gh = goal_hd;
      expected_cmds.push_back(predict_wheels(p));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        report("result with nothing expected");
      end else begin
        e = expected_cmds.pop_front();
        if (left_spd !== e.left)
          report($sformatf("left_speed %0d, want %0d", left_spd, e.left));
        if (right_spd !== e.right)
          report($sformatf("right_speed %0d, want %0d", right_spd, e.right));
        if (reached !== e.reached)
          report($sformatf("reached %b, want %b", reached, e.reached));
        if (saturated !== e.sat)
          report($sformatf("saturated %b, want %b", saturated, e.sat));
      end
    end
  end

  task automatic queue_pair(logic signed [InW-1:0] px, py, gx, gy,
                            logic signed [HdW-1:0] ph, gh);
    pose_pair_t p;
    p.px = px; p.py = py; p.gx = gx; p.gy = gy; p.ph = ph; p.gh = gh;
    pending_pairs.push_back(p);
    pushed_cnt++;
  endtask

  task automatic queue_random(int n);
    logic signed [InW-1:0] px, py, gx, gy;
    logic signed [HdW-1:0] ph, gh;
    int reach;
    for (int i = 0; i < n; i++) begin
      px = InW'($urandom);
      py = InW'($urandom);
      if ($urandom_range(0, 1)) begin
        reach = $urandom_range(0, 3) == 0 ? 4000 : 400;
        gx = InW'(px + $urandom_range(0, 2 * reach) - reach);
        gy = InW'(py + $urandom_range(0, 2 * reach) - reach);
      end else begin
        gx = InW'($urandom);
        gy = InW'($urandom);
      end
      if ($urandom_range(0, 4) == 0) begin
        ph = HdW'($urandom);
        gh = HdW'($urandom);
      end else begin
        ph = HdW'($urandom_range(0, 25736) - 12868);
        gh = HdW'($urandom_range(0, 25736) - 12868);
      end
      queue_pair(px, py, gx, gy, ph, gh);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != pushed_cnt || expected_cmds.size() != 0);
  endtask

  task automatic write_regs(logic [CfgDataW-1:0] vals [8]);
    wait_idle();
    repeat (DrainWait) @(negedge clk);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 8; i++) begin
      cfg_index <= pgmc_reg_e'(i);
      cfg_data  <= vals[i];
      do @(negedge clk); while (!cfg_taken);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [CfgDataW-1:0] vals [8];
    errors = 0; cycles = 0; pushed_cnt = 0; accepted_cnt = 0;
    in_taken = 0; cfg_taken = 0; hold_req = 0; hold_done = 0; hold_cnt = 0;
    burst_left = 0; gap_left = 0; rcv_mode = 0; rcv_cnt = 0;
    cfg_valid = 0; cfg_index = RegGainDistance; cfg_data = '0;
    in_valid = 0; out_ready = 0;
    pose_x = '0; pose_y = '0; goal_x = '0; goal_y = '0; pose_hd = '0; goal_hd = '0;
    reg_shadow[RegGainDistance]  = {1'b0, RstGainDistance};
    reg_shadow[RegGainBearing]   = RstGainBearing;
    reg_shadow[RegGainFinalHead] = RstGainFinalHead;
    reg_shadow[RegLeftRadius]    = {1'b0, RstWheelRadius};
    reg_shadow[RegRightRadius]   = {1'b0, RstWheelRadius};
    reg_shadow[RegAxleHalf]      = {1'b0, RstAxleHalf};
    reg_shadow[RegMinSpeed]      = {1'b0, RstMinSpeed};
    reg_shadow[RegArriveRadius]  = {1'b0, RstArriveRadius};
    rst_n = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    queue_pair(-32768, -32768, 32767, 32767, -12868, 12868);
    queue_pair(32767, 32767, -32768, -32768, 12868, -12868);
    queue_pair(100, 200, 100, 200, 0, 0);
    queue_pair(100, 200, 100, 200, 0, 8000);
    queue_pair(100, 200, 100, 200, 8000, 0);
    queue_pair(100, 200, 110, 190, 1000, 2000);
    queue_pair(500, 0, -500, 0, 0, 0);
    queue_pair(500, 0, -500, -1, 0, 0);
    queue_pair(0, 500, 0, -500, 0, 0);
    queue_pair(0, 0, 0, 1, -16384, 16383);
    queue_pair(0, 0, 50, 0, -16384, 16383);
    queue_pair(0, 0, 50, 0, 16383, -16384);
    queue_pair(0, 0, 100, 100, 0, 3687);
    queue_pair(0, 0, 100, 100, 3687, 0);
    queue_pair(-1, -1, 0, 0, 12868, -12868);
    queue_pair(0, 0, 0, 0, 0, 0);
    queue_random(250);
    wait_idle();
    queue_random(40);

    foreach (vals[i]) vals[i] = CfgDataW'($urandom);
    write_regs(vals);
    hold_req = 1;
    queue_random(310);

    foreach (vals[i]) vals[i] = '0;
    write_regs(vals);
    queue_random(310);

    foreach (vals[i]) vals[i] = 16'hFFFF;
    write_regs(vals);
    queue_random(310);

    vals[RegGainDistance]  = 16'h7FFF;
    vals[RegGainBearing]   = 16'h8000;
    vals[RegGainFinalHead] = 16'h7FFF;
    vals[RegLeftRadius]    = 16'd1;
    vals[RegRightRadius]   = 16'd1;
    vals[RegAxleHalf]      = 16'h7FFF;
    vals[RegMinSpeed]      = 16'd0;
    vals[RegArriveRadius]  = 16'h7FFF;
    write_regs(vals);
    queue_random(310);

    foreach (vals[i]) vals[i] = CfgDataW'($urandom);
    vals[RegLeftRadius]   = CfgDataW'($urandom_range(1, 200));
    vals[RegRightRadius]  = CfgDataW'($urandom_range(1, 200));
    vals[RegArriveRadius] = CfgDataW'($urandom_range(0, 3000));
    write_regs(vals);
    queue_random(310);

    wait_idle();
    repeat (DrainWait) @(negedge clk);
    if (errors == 0) begin
      $display("polar_goal_motion_controller_unit test passed");
    end else begin
      $display("polar_goal_motion_controller_unit test failed");
    end
    $finish;
  end

endmodule

### polar_goal_motion_controller_unit.f
hw/rtl/pgmc_pkg.sv
hw/rtl/pgmc_front.sv
hw/rtl/pgmc_fifo.sv
hw/rtl/pgmc_polar.sv
hw/rtl/pgmc_wheel_div.sv
hw/rtl/pgmc_back.sv
hw/rtl/polar_goal_motion_controller_unit.sv
test/tb_top.sv
